/* design/dsu_pkg.sv */
// dsu_pkg: shared types and constants for the union-find engine.
// No dependencies; imported by disjoint_set_union_engine.
package dsu_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int FIELD_W        = 8;   // width of node fields on the ports
  localparam int RANK_W         = 4;
  localparam int SIZE_W         = 9;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd511;

  typedef enum logic [3:0] {
    S_CLEAR,   // post-reset sweep over the tables
    S_IDLE,
    S_REDUCE,  // fold node indices into range
    S_WALK_A,
    S_COMP_A,
    S_WALK_B,
    S_COMP_B,
    S_AUX_A,   // rank/size of root_a returning
    S_LINK     // rank/size of root_b returning, link decision
  } dsu_state_t;

endpackage

/* design/disjoint_set_union_engine.sv */
// disjoint_set_union_engine: union-find over NODE_COUNT nodes with path compression.
// Depends on dsu_pkg (types, constants). Parent, rank and size tables are
// single-port-read memories inside this module.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+--------------------------
//  request  | in_action, in_node_a, in_node_b               | start & !busy
//  result   | out_root_a, out_root_b, out_same_set,          | out_valid, one cycle
//           | out_merged, out_new_root                      |
//  config   | cfg_wr_data                                   | cfg_wr_en, no wait
//
// A request folds its indices into range by subtraction (none needed when
// NODE_COUNT >= 256), walks from node_a to its root and compresses that path,
// then does the same for node_b; a union that links then reads the rank/size
// of both roots and links them. One parent memory read per hop sets the pace.
// After reset a clearing pass over all NODE_COUNT entries holds busy high.
// Results cannot be stalled; the result register frees the engine at once.
module disjoint_set_union_engine #(
  parameter int NODE_COUNT = dsu_pkg::NODE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [dsu_pkg::FIELD_W-1:0]  in_node_a,
  input  logic [dsu_pkg::FIELD_W-1:0]  in_node_b,
  output logic                         out_valid,
  output logic [dsu_pkg::FIELD_W-1:0]  out_root_a,
  output logic [dsu_pkg::FIELD_W-1:0]  out_root_b,
  output logic                         out_same_set,
  output logic                         out_merged,
  output logic [dsu_pkg::FIELD_W-1:0]  out_new_root,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data
);
  import dsu_pkg::*;

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [16:0] NC17 = 17'(NODE_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

  // tables
  logic [IW-1:0]     parent_mem [NODE_COUNT];
  logic [RANK_W-1:0] rank_mem   [NODE_COUNT];
  logic [SIZE_W-1:0] size_mem   [NODE_COUNT];
  logic [IW-1:0]     par_q;
  logic [RANK_W-1:0] rank_q;
  logic [SIZE_W-1:0] size_q;

  logic              par_we;
  logic [IW-1:0]     par_waddr, par_wdata;
  logic              rank_we, size_we;
  logic [IW-1:0]     aux_waddr, aux_raddr;
  logic [RANK_W-1:0] rank_wdata;
  logic [SIZE_W-1:0] size_wdata;

  dsu_state_t        state_r, state_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [7:0]        a_raw_r, a_raw_nxt, b_raw_r, b_raw_nxt;
  logic              action_r, action_nxt;
  logic [IW-1:0]     root_a_r, root_a_nxt, root_b_r, root_b_nxt;
  logic [RANK_W-1:0] rank_a_r, rank_a_nxt;
  logic [SIZE_W-1:0] size_a_r, size_a_nxt;
  logic              link_by_size_r;

  logic              out_valid_r, out_valid_nxt;
  logic [IW-1:0]     o_root_a_r, o_root_a_nxt, o_root_b_r, o_root_b_nxt;
  logic [IW-1:0]     o_new_root_r, o_new_root_nxt;
  logic              o_same_r, o_same_nxt, o_merged_r, o_merged_nxt;

  logic              a_ge, b_ge, roots_eq;
  logic [SIZE_W:0]   size_sum;
  logic [SIZE_W-1:0] size_sat;
  logic [RANK_W-1:0] rank_inc;

  assign a_ge     = {9'd0, a_raw_r} >= NC17;
  assign b_ge     = {9'd0, b_raw_r} >= NC17;
  assign roots_eq = (root_a_r == root_b_r);
  assign size_sum = {1'b0, size_a_r} + {1'b0, size_q};
  assign size_sat = (size_sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[SIZE_W-1:0];
  assign rank_inc = (rank_q == RANK_MAX) ? rank_q : rank_q + 4'd1;

  // memories: read address is the next walk position, so par_q tracks parent[cur_r]
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_q <= parent_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[aux_waddr] <= rank_wdata;
    end
    if (size_we) begin
      size_mem[aux_waddr] <= size_wdata;
    end
    rank_q <= rank_mem[aux_raddr];
    size_q <= size_mem[aux_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      link_by_size_r <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        link_by_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    a_raw_r      <= a_raw_nxt;
    b_raw_r      <= b_raw_nxt;
    action_r     <= action_nxt;
    root_a_r     <= root_a_nxt;
    root_b_r     <= root_b_nxt;
    rank_a_r     <= rank_a_nxt;
    size_a_r     <= size_a_nxt;
    o_root_a_r   <= o_root_a_nxt;
    o_root_b_r   <= o_root_b_nxt;
    o_new_root_r <= o_new_root_nxt;
    o_same_r     <= o_same_nxt;
    o_merged_r   <= o_merged_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    clr_nxt        = clr_r;
    a_raw_nxt      = a_raw_r;
    b_raw_nxt      = b_raw_r;
    action_nxt     = action_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    rank_a_nxt     = rank_a_r;
    size_a_nxt     = size_a_r;
    out_valid_nxt  = 1'b0;
    o_root_a_nxt   = o_root_a_r;
    o_root_b_nxt   = o_root_b_r;
    o_new_root_nxt = o_new_root_r;
    o_same_nxt     = o_same_r;
    o_merged_nxt   = o_merged_r;
    par_we         = 1'b0;
    par_waddr      = cur_r;
    par_wdata      = root_a_r;
    rank_we        = 1'b0;
    size_we        = 1'b0;
    aux_waddr      = clr_r;
    aux_raddr      = root_a_r;
    rank_wdata     = '0;
    size_wdata     = SIZE_W'(1);

    case (state_r)
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_r;
        par_wdata = clr_r;
        rank_we   = 1'b1;
        size_we   = 1'b1;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          a_raw_nxt  = in_node_a;
          b_raw_nxt  = in_node_b;
          action_nxt = in_action;
          state_nxt  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // out-of-range indices wrap by repeated subtraction
        if (a_ge) begin
          a_raw_nxt = a_raw_r - NC17[7:0];
        end
        if (b_ge) begin
          b_raw_nxt = b_raw_r - NC17[7:0];
        end
        if (!a_ge && !b_ge) begin
          cur_nxt   = IW'(a_raw_r);
          state_nxt = S_WALK_A;
        end
      end
      S_WALK_A: begin
        if (par_q == cur_r) begin
          root_a_nxt = cur_r;
          cur_nxt    = IW'(a_raw_r);
          state_nxt  = S_COMP_A;
        end else begin
          cur_nxt = par_q;
        end
      end
      S_COMP_A: begin
        if (cur_r == root_a_r) begin
          cur_nxt   = IW'(b_raw_r);
          state_nxt = S_WALK_B;
        end else begin
          par_we    = 1'b1;
          par_wdata = root_a_r;
          cur_nxt   = par_q;
        end
      end
      S_WALK_B: begin
        if (par_q == cur_r) begin
          root_b_nxt = cur_r;
          cur_nxt    = IW'(b_raw_r);
          state_nxt  = S_COMP_B;
        end else begin
          cur_nxt = par_q;
        end
      end
      S_COMP_B: begin
        if (cur_r == root_b_r) begin
          aux_raddr    = root_a_r;
          o_root_a_nxt = root_a_r;
          o_root_b_nxt = root_b_r;
          o_same_nxt   = roots_eq;
          if (action_r && !roots_eq) begin
            state_nxt = S_AUX_A;
          end else begin
            o_merged_nxt   = 1'b0;
            o_new_root_nxt = roots_eq ? root_a_r : '0;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          par_we    = 1'b1;
          par_wdata = root_b_r;
          cur_nxt   = par_q;
        end
      end
      S_AUX_A: begin
        rank_a_nxt = rank_q;
        size_a_nxt = size_q;
        aux_raddr  = root_b_r;
        state_nxt  = S_LINK;
      end
      S_LINK: begin
        // rank_q/size_q now belong to root_b
        o_merged_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (link_by_size_r) begin
          size_we    = 1'b1;
          size_wdata = size_sat;
          par_we     = 1'b1;
          if (size_a_r < size_q) begin
            par_waddr      = root_a_r;
            par_wdata      = root_b_r;
            aux_waddr      = root_b_r;
            o_new_root_nxt = root_b_r;
          end else begin
            par_waddr      = root_b_r;
            par_wdata      = root_a_r;
            aux_waddr      = root_a_r;
            o_new_root_nxt = root_a_r;
          end
        end else begin
          par_we = 1'b1;
          if (rank_a_r > rank_q) begin
            par_waddr      = root_b_r;
            par_wdata      = root_a_r;
            o_new_root_nxt = root_a_r;
          end else begin
            par_waddr      = root_a_r;
            par_wdata      = root_b_r;
            o_new_root_nxt = root_b_r;
            // tie: root_b's rank grows, saturating
            if (rank_a_r == rank_q) begin
              rank_we    = 1'b1;
              aux_waddr  = root_b_r;
              rank_wdata = rank_inc;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_root_a   = FIELD_W'(o_root_a_r);
  assign out_root_b   = FIELD_W'(o_root_b_r);
  assign out_same_set = o_same_r;
  assign out_merged   = o_merged_r;
  assign out_new_root = FIELD_W'(o_new_root_r);

endmodule

/* test/tb.sv */
// tb: self-checking testbench for disjoint_set_union_engine (union-find with path compression).
// Depends on dsu_pkg and the engine RTL. A directed table, then random requests in phases
// with varied sender gaps and linking modes, checked against a local union-find predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsu_pkg::*;

  localparam logic ACT_FIND     = 1'b0;
  localparam logic ACT_UNION    = 1'b1;
  localparam logic LINK_BY_RANK = 1'b0;
  localparam logic LINK_BY_SIZE = 1'b1;
  localparam int   QUIET_LIMIT  = 3000;
  localparam int   PHASE_ITEMS  = 110;

  typedef struct packed {
    logic [FIELD_W-1:0] root_a;
    logic [FIELD_W-1:0] root_b;
    logic               same_set;
    logic               merged;
    logic [FIELD_W-1:0] new_root;
  } roots_t;

  typedef enum logic [0:0] {ROW_REQUEST, ROW_LINK_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               mode;
    logic               action;
    logic [FIELD_W-1:0] node_a;
    logic [FIELD_W-1:0] node_b;
    logic               typed;
    roots_t             want;
  } stim_row_t;

  // Rows with typed = 1 carry their own expectation, which takes the place of the predictor's.
  localparam stim_row_t DIRECTED [24] = '{
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd0,   8'd255, 1'b1, '{8'd0, 8'd255, 1'b0, 1'b0, 8'd0}},
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd7,   8'd7,   1'b1, '{8'd7, 8'd7, 1'b1, 1'b0, 8'd7}},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd0,   8'd255, 1'b1, '{8'd0, 8'd255, 1'b0, 1'b1, 8'd0}},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd255, 8'd0,   1'b1, '{8'd0, 8'd0, 1'b1, 1'b0, 8'd0}},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd1,   8'd2,   1'b1, '{8'd1, 8'd2, 1'b0, 1'b1, 8'd1}},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd3,   8'd1,   1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd0,   8'd3,   1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd255, 8'd2,   1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd128, 8'd127, 1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd128, 8'd0,   1'b0, '0},
    '{ROW_LINK_MODE, LINK_BY_RANK, 1'b0, 8'd0, 8'd0,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd10,  8'd11,  1'b1, '{8'd10, 8'd11, 1'b0, 1'b1, 8'd11}},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd12,  8'd10,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd20,  8'd21,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd22,  8'd23,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd21,  8'd23,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd24,  8'd25,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd26,  8'd27,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd25,  8'd27,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd20,  8'd24,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd20,  8'd22,  1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_UNION, 8'd255, 8'd254, 1'b0, '0},
    '{ROW_REQUEST,   1'b0, ACT_FIND,  8'd3,   8'd255, 1'b0, '0},
    '{ROW_LINK_MODE, LINK_BY_SIZE, 1'b0, 8'd0, 8'd0,  1'b0, '0}
  };

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic               in_action   = 1'b0;
  logic [FIELD_W-1:0] in_node_a   = '0;
  logic [FIELD_W-1:0] in_node_b   = '0;
  logic               out_valid;
  logic [FIELD_W-1:0] out_root_a;
  logic [FIELD_W-1:0] out_root_b;
  logic               out_same_set;
  logic               out_merged;
  logic [FIELD_W-1:0] out_new_root;
  logic               cfg_wr_en   = 1'b0;
  logic               cfg_wr_data = 1'b0;

  // request-side sideband: a typed expectation travelling with the current request
  logic   req_typed = 1'b0;
  roots_t req_want  = '0;

  // predictor state
  logic [FIELD_W-1:0] parent_of [256];
  logic [RANK_W-1:0]  rank_of   [256];
  logic [SIZE_W-1:0]  size_of   [256];
  logic               size_linking;

  roots_t      expected_roots [$];
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;
  int unsigned n_finds      = 0;
  int unsigned n_unions     = 0;
  int unsigned n_links      = 0;
  int unsigned n_same       = 0;

  disjoint_set_union_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_root_a   (out_root_a),
    .out_root_b   (out_root_b),
    .out_same_set (out_same_set),
    .out_merged   (out_merged),
    .out_new_root (out_new_root),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk to the root, then point every entry on the path straight at it.
  function automatic logic [FIELD_W-1:0] root_with_compression(input logic [FIELD_W-1:0] node);
    logic [FIELD_W-1:0] root;
    logic [FIELD_W-1:0] cur;
    logic [FIELD_W-1:0] up;
    int                 hops;
    root = node;
    hops = 0;
    while (hops < 256 && parent_of[root] != root) begin
      root = parent_of[root];
      hops++;
    end
    cur  = node;
    hops = 0;
    while (hops < 256 && cur != root) begin
      up             = parent_of[cur];
      parent_of[cur] = root;
      cur            = up;
      hops++;
    end
    return root;
  endfunction

  task automatic resolve_and_link(input logic act, input logic [FIELD_W-1:0] na,
                                  input logic [FIELD_W-1:0] nb, output roots_t r);
    logic [FIELD_W-1:0] ra;
    logic [FIELD_W-1:0] rb;
    logic [SIZE_W:0]    sum;
    ra         = root_with_compression(na);
    rb         = root_with_compression(nb);
    r.root_a   = ra;
    r.root_b   = rb;
    r.same_set = (ra == rb);
    r.merged   = 1'b0;
    r.new_root = (ra == rb) ? ra : '0;
    if (act == ACT_UNION && ra != rb) begin
      r.merged = 1'b1;
      if (size_linking == LINK_BY_SIZE) begin
        sum = {1'b0, size_of[ra]} + {1'b0, size_of[rb]};
        if (sum > {1'b0, SIZE_MAX}) sum = {1'b0, SIZE_MAX};
        if (size_of[ra] < size_of[rb]) begin
          parent_of[ra] = rb;
          size_of[rb]   = sum[SIZE_W-1:0];
          r.new_root    = rb;
        end else begin
          parent_of[rb] = ra;
          size_of[ra]   = sum[SIZE_W-1:0];
          r.new_root    = ra;
        end
      end else begin
        if (rank_of[ra] < rank_of[rb]) begin
          parent_of[ra] = rb;
          r.new_root    = rb;
        end else if (rank_of[ra] > rank_of[rb]) begin
          parent_of[rb] = ra;
          r.new_root    = ra;
        end else begin
          // tie: first root goes under the second, which gains a rank
          parent_of[ra] = rb;
          if (rank_of[rb] < RANK_MAX) rank_of[rb] = rank_of[rb] + RANK_W'(1);
          r.new_root    = rb;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Acceptance, prediction and result checking, all on the rising edge.
  always @(posedge clk) begin
    roots_t want;
    roots_t got;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_wr_en) begin
        size_linking = cfg_wr_data;
        quiet_cycles = 0;
      end
      if (start && !busy) begin
        resolve_and_link(in_action, in_node_a, in_node_b, want);
        if (in_action == ACT_UNION) n_unions++;
        else n_finds++;
        if (want.merged) n_links++;
        if (want.same_set) n_same++;
        if (req_typed) want = req_want;
        expected_roots.push_back(want);
        quiet_cycles = 0;
      end
      if (out_valid) begin
        got = '{out_root_a, out_root_b, out_same_set, out_merged, out_new_root};
        quiet_cycles = 0;
        if (expected_roots.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request outstanding, expected none, actual %h",
                   $time, got);
        end else begin
          want = expected_roots.pop_front();
          check_field("root_a", want.root_a, got.root_a);
          check_field("root_b", want.root_b, got.root_b);
          check_field("same_set", want.same_set, got.same_set);
          check_field("merged", want.merged, got.merged);
          check_field("new_root", want.new_root, got.new_root);
        end
      end
    end
  end

  // Entered and left just after a falling edge.
  task automatic issue_request(input logic act, input logic [FIELD_W-1:0] na,
                               input logic [FIELD_W-1:0] nb, input logic typed,
                               input roots_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_node_a <= na;
    in_node_b <= nb;
    req_typed <= typed;
    req_want  <= want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold requests off until every outstanding result is back and the engine is free.
  task automatic settle_engine();
    start <= 1'b0;
    while (expected_roots.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_link_mode(input logic by_size);
    settle_engine();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= by_size;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_node();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return FIELD_W'($urandom_range(255));
    endcase
  endfunction

  // Watchdog: gives up after a long stretch with no request, result or register write.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("** disjoint_set_union_engine: FAILED **");
    $finish;
  end

  initial begin
    int                 phase;
    int                 i;
    int                 idle_pct [4];
    logic               act;
    logic [FIELD_W-1:0] na;
    logic [FIELD_W-1:0] nb;
    idle_pct = '{0, 73, 0, 36};
    for (i = 0; i < 256; i++) begin
      parent_of[i] = FIELD_W'(i);
      rank_of[i]   = '0;
      size_of[i]   = SIZE_W'(1);
    end
    size_linking = LINK_BY_SIZE;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_LINK_MODE) set_link_mode(DIRECTED[r].mode);
      else issue_request(DIRECTED[r].action, DIRECTED[r].node_a, DIRECTED[r].node_b,
                         DIRECTED[r].typed, DIRECTED[r].want, 0);
    end

    for (phase = 0; phase < 4; phase++) begin
      set_link_mode(phase[0] ? LINK_BY_SIZE : LINK_BY_RANK);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // a mid-phase drain, so the engine also sees a request after a full pause
        if (i == PHASE_ITEMS / 2 && phase == 1) settle_engine();
        act = ($urandom_range(99) < 60) ? ACT_UNION : ACT_FIND;
        na  = pick_node();
        nb  = ($urandom_range(19) == 0) ? na : pick_node();
        issue_request(act, na, nb, 1'b0, '0, idle_pct[phase]);
      end
    end

    settle_engine();
    repeat (10) @(negedge clk);
    $display("Covered %0d finds and %0d unions (%0d linked, %0d already joined)",
             n_finds, n_unions, n_links, n_same);
    $display("under rank and size linking, with sender gaps of 0, 36 and 73 percent.");
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("** disjoint_set_union_engine: PASSED **");
    end else begin
      $display("** disjoint_set_union_engine: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
design/dsu_pkg.sv
design/disjoint_set_union_engine.sv
test/tb.sv
